// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the scheduler unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/sstf_pkg.sv =====
// types and constants of the sstf disk request scheduler
package sstf_pkg;

  localparam int REQ_W   = 8;
  localparam int TRK_W   = 16;
  localparam int CFG_W   = 5;
  localparam int QCNT_W  = 5;

  localparam logic [CFG_W-1:0] MAX_QUEUE_RST = CFG_W'(16);

  localparam logic REQ_ENQUEUE = 1'b0;
  localparam logic REQ_POLL    = 1'b1;

  typedef struct packed {
    logic [REQ_W-1:0] requester;
    logic [TRK_W-1:0] track;
  } slot_t;

  typedef struct packed {
    logic clear;
    logic cmp_en;
  } pick_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ,
    ST_SCAN,
    ST_LAST,
    ST_COMMIT
  } state_t;

endpackage

// ===== rtl/core/sstf_slot_ram.sv =====
// slot memory: one write port, one registered read port
module sstf_slot_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 24,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/sstf_seek_pick.sv =====
// nearest-track selection: one distance compare per slot beat
module sstf_seek_pick import sstf_pkg::*; #(
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pick_ctl_t        ctl,
  input  logic [IDX_W-1:0] cmp_idx,
  input  slot_t            cand,
  input  logic [TRK_W-1:0] head_track,
  output logic [IDX_W-1:0] best_idx,
  output slot_t            best,
  output logic             best_have
);

  logic             have_r, have_nxt;
  logic [TRK_W-1:0] best_d_r;
  logic [IDX_W-1:0] best_idx_r;
  slot_t            best_r;
  logic [TRK_W-1:0] seek_gap;
  logic             take;

  always_comb begin
    if (cand.track >= head_track) begin
      seek_gap = cand.track - head_track;
    end else begin
      seek_gap = head_track - cand.track;
    end
  end

  // strict less-than keeps the lowest slot on a tie
  assign take = ctl.cmp_en && (!have_r || (seek_gap < best_d_r));

  always_comb begin
    have_nxt = have_r;
    if (ctl.clear) begin
      have_nxt = 1'b0;
    end else if (take) begin
      have_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else begin
      have_r <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !ctl.clear) begin
      best_d_r   <= seek_gap;
      best_idx_r <= cmp_idx;
      best_r     <= cand;
    end
  end

  assign best_idx  = best_idx_r;
  assign best      = best_r;
  assign best_have = have_r;

endmodule

// ===== rtl/core/sstf_disk_request_scheduler_unit.sv =====
// sstf disk request scheduler: slot memory, scan sequencer and result register
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------------
//  in_      | start & !busy      | req_type, requester_id, track, inputs_drained
//  out_     | out_valid strobe   | accepted, served, served_requester/track, count
//  cfg_     | cfg_valid & ready  | cfg_data = max_queue
//
// rejected enqueue or poll that serves nothing: answered from idle, result on the next cycle
// enqueue: walks the valid bits to the lowest free slot and writes the request there
// serving poll: one slot memory read and one distance compare per cycle in the scan,
//   then ST_LAST compares the last beat and ST_COMMIT removes the winner
// synchronous active-low reset empties the queue, clears the head track and sets max_queue to 16
// results are strobed for one cycle; the receiver cannot stall them
`include "assert_macros.svh"

module sstf_disk_request_scheduler_unit import sstf_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_req_type,
  input  logic [REQ_W-1:0]  in_requester_id,
  input  logic [TRK_W-1:0]  in_track,
  input  logic              in_inputs_drained,
  output logic              out_valid,
  output logic              out_accepted,
  output logic              out_served,
  output logic [REQ_W-1:0]  out_served_requester,
  output logic [TRK_W-1:0]  out_served_track,
  output logic [QCNT_W-1:0] out_queue_count,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [QUEUE_DEPTH-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [TRK_W-1:0]       head_r, head_nxt;
  logic [CFG_W-1:0]       max_queue_r, max_queue_nxt;
  logic                   chk_en_r, chk_en_nxt;
  logic [IDX_W-1:0]       chk_idx_r, chk_idx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  slot_t                  enq_r, enq_nxt;
  logic                   out_acc_r, out_acc_nxt;
  logic                   out_srv_r, out_srv_nxt;
  slot_t                  out_slot_r, out_slot_nxt;
  logic [QCNT_W-1:0]      out_cnt_r, out_cnt_nxt;

  logic             in_fire;
  logic [CMP_W-1:0] lim;
  logic [CMP_W-1:0] cnt_cmp;
  logic [CMP_W-1:0] cnt_nxt_ext;
  logic             room;
  logic             serve_ok;
  logic             idx_last;
  logic             slot_free;

  logic             wr_en;
  logic             rd_en;
  slot_t            rd_slot;
  pick_ctl_t        pick_ctl;
  logic [IDX_W-1:0] best_idx;
  slot_t            best_slot;
  logic             best_have;

  assign busy      = (state_r != ST_IDLE);
  assign in_fire   = start && !busy;
  assign cfg_ready = 1'b1;

  // limit in use is min(max_queue, QUEUE_DEPTH)
  assign lim = (CMP_W'(max_queue_r) > CMP_W'(QUEUE_DEPTH)) ? CMP_W'(QUEUE_DEPTH)
                                                           : CMP_W'(max_queue_r);
  assign cnt_cmp   = CMP_W'(cnt_r);
  assign room      = (cnt_cmp < lim);
  assign serve_ok  = (cnt_r != '0) && ((cnt_cmp >= lim) || in_inputs_drained);
  assign idx_last  = (idx_r == IDX_LAST);
  assign slot_free = !valid_r[idx_r];

  sstf_slot_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH ($bits(slot_t)),
    .AW    (IDX_W)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_r),
    .wr_data (enq_r),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_slot)
  );

  sstf_seek_pick #(
    .IDX_W (IDX_W)
  ) u_seek_pick (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (pick_ctl),
    .cmp_idx    (chk_idx_r),
    .cand       (rd_slot),
    .head_track (head_r),
    .best_idx   (best_idx),
    .best       (best_slot),
    .best_have  (best_have)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_req_type == REQ_ENQUEUE) begin
            if (room) begin
              state_nxt = ST_ENQ;
            end
          end else if (serve_ok) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_ENQ: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (idx_last) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST:   state_nxt = ST_COMMIT;
      ST_COMMIT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    idx_nxt       = idx_r;
    valid_nxt     = valid_r;
    cnt_nxt       = cnt_r;
    head_nxt      = head_r;
    enq_nxt       = enq_r;
    chk_en_nxt    = 1'b0;
    chk_idx_nxt   = idx_r;
    out_valid_nxt = 1'b0;
    out_acc_nxt   = out_acc_r;
    out_srv_nxt   = out_srv_r;
    out_slot_nxt  = out_slot_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    pick_ctl      = '0;

    max_queue_nxt = (cfg_valid && cfg_ready) ? cfg_data : max_queue_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          idx_nxt           = '0;
          enq_nxt.requester = in_requester_id;
          enq_nxt.track     = in_track;
          pick_ctl.clear    = 1'b1;
          // nothing to walk: answer right away
          if (!(((in_req_type == REQ_ENQUEUE) && room) ||
                ((in_req_type == REQ_POLL) && serve_ok))) begin
            out_valid_nxt = 1'b1;
            out_acc_nxt   = 1'b0;
            out_srv_nxt   = 1'b0;
            out_slot_nxt  = '0;
          end
        end
      end
      ST_ENQ: begin
        if (slot_free) begin
          wr_en            = 1'b1;
          valid_nxt[idx_r] = 1'b1;
          cnt_nxt          = cnt_r + CNT_W'(1);
          out_valid_nxt    = 1'b1;
          out_acc_nxt      = 1'b1;
          out_srv_nxt      = 1'b0;
          out_slot_nxt     = '0;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_SCAN: begin
        rd_en       = 1'b1;
        chk_en_nxt  = valid_r[idx_r];
        chk_idx_nxt = idx_r;
        if (!idx_last) begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_LAST: begin
        pick_ctl.cmp_en = chk_en_r;
      end
      ST_COMMIT: begin
        valid_nxt[best_idx] = 1'b0;
        cnt_nxt             = cnt_r - CNT_W'(1);
        head_nxt            = best_slot.track;
        out_valid_nxt       = 1'b1;
        out_acc_nxt         = 1'b0;
        out_srv_nxt         = 1'b1;
        out_slot_nxt        = best_slot;
      end
      default: begin
      end
    endcase

    // compare of the beat read in the previous scan cycle
    if (state_r == ST_SCAN) begin
      pick_ctl.cmp_en = chk_en_r;
    end

    cnt_nxt_ext = CMP_W'(cnt_nxt);
    out_cnt_nxt = out_valid_nxt ? cnt_nxt_ext[QCNT_W-1:0] : out_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      valid_r     <= '0;
      cnt_r       <= '0;
      head_r      <= '0;
      max_queue_r <= MAX_QUEUE_RST;
      chk_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      max_queue_r <= max_queue_nxt;
      chk_en_r    <= chk_en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r  <= chk_idx_nxt;
    enq_r      <= enq_nxt;
    out_acc_r  <= out_acc_nxt;
    out_srv_r  <= out_srv_nxt;
    out_slot_r <= out_slot_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_accepted         = out_acc_r;
  assign out_served           = out_srv_r;
  assign out_served_requester = out_slot_r.requester;
  assign out_served_track     = out_slot_r.track;
  assign out_queue_count      = out_cnt_r;

  `ASSERT_CLK(a_cnt_matches_valid, ($countones(valid_r) == int'(cnt_r)),
              "entry count differs from number of valid slots")
  `ASSERT_CLK(a_enq_has_room, ((state_r == ST_ENQ) |-> (int'(cnt_r) < QUEUE_DEPTH)),
              "enqueue walk started on a full queue")
  `ASSERT_CLK(a_commit_has_winner, ((state_r == ST_COMMIT) |-> (best_have && valid_r[best_idx])),
              "removal without a valid nearest slot")
  `ASSERT_NEVER(a_acc_and_srv, (out_valid_r && out_acc_r && out_srv_r),
                "result beat both accepted and served")
  `ASSERT_CLK(a_scan_leaves_queue, ((state_r == ST_SCAN) |-> (cnt_r != '0)),
              "poll scan entered with an empty queue")

endmodule

// ===== tb/sv/sstf_disk_request_scheduler_unit_tb.sv =====
// self-checking testbench for the sstf disk request scheduler unit
`timescale 1ns / 1ps

module sstf_disk_request_scheduler_unit_tb;
  import sstf_pkg::*;

  localparam int DEPTH = 16;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 62;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic              kind;
    logic [REQ_W-1:0]  rid;
    logic [TRK_W-1:0]  trk;
    logic              drained;
  } cmd_t;

  typedef struct packed {
    logic              accepted;
    logic              served;
    logic [REQ_W-1:0]  req;
    logic [TRK_W-1:0]  trk;
    logic [QCNT_W-1:0] count;
  } sched_res_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_req_type = 1'b0;
  logic [REQ_W-1:0]  in_requester_id = '0;
  logic [TRK_W-1:0]  in_track = '0;
  logic              in_inputs_drained = 1'b0;
  logic              out_valid;
  logic              out_accepted;
  logic              out_served;
  logic [REQ_W-1:0]  out_served_requester;
  logic [TRK_W-1:0]  out_served_track;
  logic [QCNT_W-1:0] out_queue_count;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data = '0;

  sstf_disk_request_scheduler_unit #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_req_type          (in_req_type),
    .in_requester_id      (in_requester_id),
    .in_track             (in_track),
    .in_inputs_drained    (in_inputs_drained),
    .out_valid            (out_valid),
    .out_accepted         (out_accepted),
    .out_served           (out_served),
    .out_served_requester (out_served_requester),
    .out_served_track     (out_served_track),
    .out_queue_count      (out_queue_count),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_data             (cfg_data)
  );

  always #5 clk = ~clk;

  cmd_t       cmd_backlog[$];
  sched_res_t due_results[$];
  int         gap_pct = 10;
  int         errors = 0;
  int         stall_cycles = 0;

  // scheduler mirror
  logic [CFG_W-1:0] queue_limit = MAX_QUEUE_RST;
  logic             slot_on [DEPTH] = '{default: 1'b0};
  logic [REQ_W-1:0] slot_req [DEPTH];
  logic [TRK_W-1:0] slot_trk [DEPTH];
  int               held = 0;
  logic [TRK_W-1:0] head_pos = '0;

  function automatic sched_res_t predict_schedule(logic kind, logic [REQ_W-1:0] rid,
                                                  logic [TRK_W-1:0] trk, logic drained);
    sched_res_t r;
    int lim;
    int pick;
    logic [TRK_W-1:0] span;
    logic [TRK_W-1:0] best_gap;
    r = '0;
    lim = (queue_limit > DEPTH) ? DEPTH : queue_limit;
    pick = -1;
    best_gap = '0;
    if (kind == REQ_ENQUEUE) begin
      if (held < lim) begin
        for (int i = 0; i < DEPTH; i++)
          if (!slot_on[i] && pick < 0) pick = i;
        if (pick >= 0) begin
          slot_on[pick] = 1'b1;
          slot_req[pick] = rid;
          slot_trk[pick] = trk;
          held++;
          r.accepted = 1'b1;
        end
      end
    end else if (held > 0 && (held >= lim || drained)) begin
      // nearest track to the head, lowest slot on a tie
      for (int i = 0; i < DEPTH; i++) begin
        if (slot_on[i]) begin
          span = (slot_trk[i] >= head_pos) ? slot_trk[i] - head_pos : head_pos - slot_trk[i];
          if (pick < 0 || span < best_gap) begin
            pick = i;
            best_gap = span;
          end
        end
      end
      if (pick >= 0) begin
        r.served = 1'b1;
        r.req = slot_req[pick];
        r.trk = slot_trk[pick];
        slot_on[pick] = 1'b0;
        held--;
        head_pos = slot_trk[pick];
      end
    end
    r.count = held[QCNT_W-1:0];
    return r;
  endfunction

  task automatic report_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  // driver: holds the front item until it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) cmd_backlog.delete(0);
      if (!(start && busy)) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
          start <= 1'b1;
          in_req_type <= cmd_backlog[0].kind;
          in_requester_id <= cmd_backlog[0].rid;
          in_track <= cmd_backlog[0].trk;
          in_inputs_drained <= cmd_backlog[0].drained;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: results first, then the beat taken at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with no request outstanding", $time);
          errors++;
        end else begin
          report_field("accepted", due_results[0].accepted, out_accepted);
          report_field("served", due_results[0].served, out_served);
          report_field("served_requester", due_results[0].req, out_served_requester);
          report_field("served_track", due_results[0].trk, out_served_track);
          report_field("queue_count", due_results[0].count, out_queue_count);
          due_results.delete(0);
        end
      end
      if (cfg_valid && cfg_ready) queue_limit = cfg_data;
      if (start && !busy)
        due_results.insert(due_results.size(),
                           predict_schedule(in_req_type, in_requester_id, in_track,
                                            in_inputs_drained));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("sstf_disk_request_scheduler_unit: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic void add_cmd(logic kind, logic [REQ_W-1:0] rid, logic [TRK_W-1:0] trk,
                                  logic drained);
    cmd_t c;
    c = '{kind, rid, trk, drained};
    cmd_backlog.insert(cmd_backlog.size(), c);
  endfunction

  function automatic cmd_t random_cmd(int enq_pct);
    cmd_t c;
    c.kind = ($urandom_range(99) < enq_pct) ? REQ_ENQUEUE : REQ_POLL;
    c.rid = REQ_W'($urandom_range(255));
    // clustered tracks make distance ties common
    case ($urandom_range(3))
      0: c.trk = TRK_W'($urandom_range(15));
      1: c.trk = $urandom_range(1) ? '1 : '0;
      default: c.trk = TRK_W'($urandom);
    endcase
    c.drained = 1'($urandom_range(1));
    return c;
  endfunction

  task automatic settle_then_configure(input logic [CFG_W-1:0] value);
    while (cmd_backlog.size() != 0 || due_results.size() != 0 || start) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] limits [PHASES];
    limits = '{5'd31, 5'd2, 5'd16, 5'd17, 5'd5, 5'd1, 5'd0, 5'd8, 5'd31, 5'd3, 5'd16, 5'd4};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limit: empty poll, extremes, ties on both sides of the head
    add_cmd(REQ_POLL, 8'd0, 16'd0, 1'b1);
    add_cmd(REQ_ENQUEUE, 8'd255, 16'hFFFF, 1'b0);
    add_cmd(REQ_ENQUEUE, 8'd0, 16'd0, 1'b0);
    add_cmd(REQ_ENQUEUE, 8'hAA, 16'd100, 1'b1);
    add_cmd(REQ_ENQUEUE, 8'h55, 16'd100, 1'b0);
    add_cmd(REQ_POLL, 8'd7, 16'd9, 1'b0);
    add_cmd(REQ_POLL, 8'd0, 16'd0, 1'b1);
    add_cmd(REQ_POLL, 8'd0, 16'd0, 1'b1);
    add_cmd(REQ_ENQUEUE, 8'd1, 16'd50, 1'b0);
    add_cmd(REQ_ENQUEUE, 8'd2, 16'd150, 1'b0);
    add_cmd(REQ_POLL, 8'hFF, 16'hFFFF, 1'b1);
    add_cmd(REQ_POLL, 8'd0, 16'd0, 1'b1);

    // zero limit with entries left: polls serve, enqueues bounce
    settle_then_configure(5'd0);
    add_cmd(REQ_ENQUEUE, 8'd3, 16'd3, 1'b0);
    add_cmd(REQ_POLL, 8'd0, 16'd0, 1'b0);
    add_cmd(REQ_POLL, 8'd0, 16'd0, 1'b0);
    add_cmd(REQ_POLL, 8'd0, 16'd0, 1'b1);
    add_cmd(REQ_ENQUEUE, 8'd4, 16'd4, 1'b1);

    // limit of one: full after a single entry
    settle_then_configure(5'd1);
    add_cmd(REQ_ENQUEUE, 8'd5, 16'd1234, 1'b0);
    add_cmd(REQ_ENQUEUE, 8'd6, 16'd4321, 1'b0);
    add_cmd(REQ_POLL, 8'd0, 16'd0, 1'b0);
    add_cmd(REQ_POLL, 8'd0, 16'd0, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      if (p >= 8) limits[p] = (p == 8 || p == 9) ? 5'($urandom_range(31)) : limits[p];
      settle_then_configure(limits[p]);
      gap_pct = (p < 4) ? 10 : (p < 8) ? 62 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++)
        cmd_backlog.insert(cmd_backlog.size(), random_cmd((p % 2 == 0) ? 70 : 45));
    end

    while (cmd_backlog.size() != 0 || due_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    errors += due_results.size();
    if (errors == 0) begin
      $display("sstf_disk_request_scheduler_unit: match");
    end else begin
      $display("sstf_disk_request_scheduler_unit: mismatch");
    end
    $finish;
  end

endmodule
